>>> rtl/ftt_pkg.sv
// ----------------------------------------------------------------------------
// ftt_pkg
// Shared types and constants of the finish termination tracker.
// ----------------------------------------------------------------------------
package ftt_pkg;

	localparam int PLACE_W     = 4;
	localparam int FIELD_CNT_W = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 4;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [1:0] {
		ACT_LOCAL_SPAWN  = 2'd0,
		ACT_LOCAL_DONE   = 2'd1,
		ACT_REMOTE_SPAWN = 2'd2,
		ACT_REMOTE_ACK   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_UNDERFLOW = 2'd1,
		ERR_ACK_OVER  = 2'd2,
		ERR_RETIRED   = 2'd3
	} err_t;

	localparam logic [CFG_IDX_W-1:0] REG_HERE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PARENT = 2'd2;

endpackage

>>> rtl/ftt_count_mem.sv
// ----------------------------------------------------------------------------
// ftt_count_mem
// Per-place incoming count memory with seen bits. One registered read and
// one write per cycle; a never-seen entry reads as zero, and a write to the
// entry read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module ftt_count_mem #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] ra,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [DATA_W-1:0]        wd,
	input  logic                     mark,
	output logic                     rd_seen,
	output logic [DATA_W-1:0]        rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] fwd_data_q;
	logic [AW-1:0]     ra_q;
	logic              fwd_q;
	logic [DEPTH-1:0]  seen_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q       <= mem[ra];
			ra_q       <= ra;
			fwd_data_q <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			fwd_q  <= 1'b0;
		end else begin
			if (we && mark) begin
				seen_q[wa] <= 1'b1;
			end
			if (re) begin
				fwd_q <= we && (wa == ra);
			end
		end
	end

	assign rd_seen = seen_q[ra_q];
	assign rd_data = fwd_q ? fwd_data_q : (rd_seen ? rd_q : '0);

endmodule

>>> rtl/finish_termination_tracker_unit.sv
// ----------------------------------------------------------------------------
// finish_termination_tracker_unit
// Termination tracking of one distributed finish scope at one node.
// ----------------------------------------------------------------------------
// Spawn, destroy and ack events are taken one per cycle while the output
// register has room: the count memory is read when an item is accepted and
// updated when the item is processed, with a write-to-read forward between
// back-to-back items. A destroy that brings the local count to zero starts a
// walk over the count memory, one place per cycle unless output backpressure
// stalls it, and input is held until the walk and any parent ack are done.
// Results leave through a single output register.
module finish_termination_tracker_unit #(
	parameter int NUM_PLACES  = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ftt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // place[3:0], count[19:4], zero
	input  logic [1:0]                       s_axis_tuser,  // action
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [ftt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // ack_place[3:0], ack_count[19:4],
	                                                         // terminated[20], retired[21],
	                                                         // error_code[23:22]
	output logic                             m_axis_tuser,  // ack_valid
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ftt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ftt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import ftt_pkg::*;

	localparam int IW   = $clog2(NUM_PLACES);
	localparam int PTRW = $clog2(NUM_PLACES + 1);
	localparam int CW   = COUNT_WIDTH;
	localparam int CMW  = (CW > FIELD_CNT_W) ? CW : FIELD_CNT_W;
	localparam int PCW  = (IW > PLACE_W) ? IW : PLACE_W;

	typedef enum logic [1:0] {
		M_RUN,
		M_WALK,
		M_WEND,
		M_PACK
	} mode_t;

	function automatic logic [IW-1:0] place_idx(input logic [PLACE_W-1:0] p);
		logic [PLACE_W:0] v;
		v = {1'b0, p};
		for (int k = 0; k < 8; k++) begin
			if (int'(v) >= NUM_PLACES) begin
				v = v - (PLACE_W + 1)'(NUM_PLACES);
			end
		end
		return IW'(v);
	endfunction

	mode_t                mode_q, mode_d;
	logic                 valid_s1, valid_s1_d;
	action_t              act_s1;
	logic [FIELD_CNT_W-1:0] cnt_s1;
	logic [IW-1:0]        idx_s1;
	logic [CW-1:0]        local_q, local_d;
	logic [CW-1:0]        out_q, out_d;
	logic                 retired_q, retired_d;
	logic [PLACE_W-1:0]   here_q, root_q, parent_q;
	logic [PTRW-1:0]      ptr_q, ptr_d;
	logic                 wv_q, wv_d;
	logic [IW-1:0]        walk_idx_s1, walk_idx_d;
	logic                 pend_valid_q, pend_valid_d;
	logic [PLACE_W-1:0]   pend_place_q, pend_place_d;
	logic [FIELD_CNT_W-1:0] pend_count_q, pend_count_d;

	logic                 m_valid_q;
	logic                 m_ackv_q, m_term_q, m_ret_q, m_last_q;
	logic [PLACE_W-1:0]   m_place_q;
	logic [FIELD_CNT_W-1:0] m_count_q;
	err_t                 m_err_q;

	logic                 push, p_ackv, p_term, p_ret, p_last;
	logic [PLACE_W-1:0]   p_place;
	logic [FIELD_CNT_W-1:0] p_count;
	err_t                 p_err;

	logic                 mem_re, mem_we, mem_mark, rd_seen;
	logic [IW-1:0]        mem_ra, mem_wa;
	logic [CW-1:0]        mem_wd, rd_data;

	logic                 can_push, is_root, need_par, walk_go, in_ready, accept;
	logic                 cand, emit, stall;
	logic [IW-1:0]        par_idx;
	action_t              in_action;
	logic [PLACE_W-1:0]   in_place;
	logic [FIELD_CNT_W-1:0] in_count;

	assign in_action = action_t'(s_axis_tuser);
	assign in_place  = s_axis_tdata[PLACE_W-1:0];
	assign in_count  = s_axis_tdata[PLACE_W +: FIELD_CNT_W];

	assign can_push = !m_valid_q || m_axis_tready;
	assign is_root  = (here_q == root_q);
	assign need_par = (out_q == '0) && !is_root;
	assign par_idx  = place_idx(parent_q);
	assign walk_go  = valid_s1 && !retired_q && (act_s1 == ACT_LOCAL_DONE) &&
	                  (local_q == CW'(1));
	assign in_ready = (mode_q == M_RUN) && (!valid_s1 || (can_push && !walk_go));
	assign accept   = s_axis_tvalid && in_ready;

	assign cand  = wv_q && rd_seen && (PCW'(walk_idx_s1) != PCW'(parent_q));
	assign emit  = cand && (PCW'(walk_idx_s1) != PCW'(here_q));
	assign stall = emit && pend_valid_q && !can_push;

	ftt_count_mem #(
		.DEPTH  (NUM_PLACES),
		.DATA_W (CW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (mem_re),
		.ra      (mem_ra),
		.we      (mem_we),
		.wa      (mem_wa),
		.wd      (mem_wd),
		.mark    (mem_mark),
		.rd_seen (rd_seen),
		.rd_data (rd_data)
	);

	always_comb begin
		mode_d       = mode_q;
		valid_s1_d   = valid_s1;
		local_d      = local_q;
		out_d        = out_q;
		retired_d    = retired_q;
		ptr_d        = ptr_q;
		wv_d         = wv_q;
		walk_idx_d   = walk_idx_s1;
		pend_valid_d = pend_valid_q;
		pend_place_d = pend_place_q;
		pend_count_d = pend_count_q;
		push         = 1'b0;
		p_ackv       = 1'b0;
		p_place      = '0;
		p_count      = '0;
		p_term       = (out_q == '0);
		p_ret        = need_par;
		p_err        = ERR_NONE;
		p_last       = 1'b1;
		mem_re       = 1'b0;
		mem_ra       = walk_idx_s1;
		mem_we       = 1'b0;
		mem_wa       = idx_s1;
		mem_wd       = '0;
		mem_mark     = 1'b0;

		unique case (mode_q)
			M_RUN: begin
				if (valid_s1 && can_push) begin
					valid_s1_d = 1'b0;
					push       = 1'b1;
					if (retired_q) begin
						p_err = ERR_RETIRED;
					end else begin
						unique case (act_s1)
							ACT_LOCAL_SPAWN: begin
								local_d  = local_q + CW'(1);
								mem_we   = 1'b1;
								mem_wd   = rd_data + CW'(1);
								mem_mark = 1'b1;
							end
							ACT_LOCAL_DONE: begin
								if (local_q == '0) begin
									p_err = ERR_UNDERFLOW;
								end else begin
									local_d = local_q - CW'(1);
									if (walk_go) begin
										push         = 1'b0;
										mode_d       = M_WALK;
										ptr_d        = '0;
										wv_d         = 1'b0;
										pend_valid_d = 1'b0;
									end
								end
							end
							ACT_REMOTE_SPAWN: begin
								out_d = out_q + CW'(1);
							end
							ACT_REMOTE_ACK: begin
								if (CMW'(cnt_s1) > CMW'(out_q)) begin
									p_err = ERR_ACK_OVER;
								end else begin
									out_d = CW'(CMW'(out_q) - CMW'(cnt_s1));
									if (out_d == '0 && local_q == '0 && !is_root) begin
										p_ackv    = 1'b1;
										p_place   = parent_q;
										p_count   = FIELD_CNT_W'(rd_data);
										mem_we    = 1'b1;
										retired_d = 1'b1;
									end
								end
							end
						endcase
					end
					p_term = (local_d == '0) && (out_d == '0);
					p_ret  = retired_d;
				end
				if (accept) begin
					valid_s1_d = 1'b1;
					mem_re     = 1'b1;
					mem_ra     = (in_action == ACT_LOCAL_SPAWN) ? place_idx(in_place) : par_idx;
				end
			end
			M_WALK: begin
				if (!stall) begin
					if (cand) begin
						mem_we = 1'b1;
						mem_wa = walk_idx_s1;
					end
					if (emit) begin
						if (pend_valid_q) begin
							push    = 1'b1;
							p_ackv  = 1'b1;
							p_place = pend_place_q;
							p_count = pend_count_q;
							p_last  = 1'b0;
						end
						pend_valid_d = 1'b1;
						pend_place_d = PLACE_W'(walk_idx_s1);
						pend_count_d = FIELD_CNT_W'(rd_data);
					end
					if (ptr_q != PTRW'(NUM_PLACES)) begin
						mem_re     = 1'b1;
						mem_ra     = ptr_q[IW-1:0];
						walk_idx_d = ptr_q[IW-1:0];
						wv_d       = 1'b1;
						ptr_d      = ptr_q + PTRW'(1);
					end else begin
						wv_d = 1'b0;
						if (!wv_q) begin
							mode_d = M_WEND;
						end
					end
				end
			end
			M_WEND: begin
				if (pend_valid_q) begin
					if (can_push) begin
						push         = 1'b1;
						p_ackv       = 1'b1;
						p_place      = pend_place_q;
						p_count      = pend_count_q;
						p_last       = !need_par;
						pend_valid_d = 1'b0;
						if (!need_par) begin
							mode_d = M_RUN;
						end
					end
				end else if (need_par) begin
					mem_re = 1'b1;
					mem_ra = par_idx;
					mode_d = M_PACK;
				end else if (can_push) begin
					push   = 1'b1;
					mode_d = M_RUN;
				end
			end
			M_PACK: begin
				if (can_push) begin
					push      = 1'b1;
					p_ackv    = 1'b1;
					p_place   = parent_q;
					p_count   = FIELD_CNT_W'(rd_data);
					mem_we    = 1'b1;
					mem_wa    = par_idx;
					retired_d = 1'b1;
					mode_d    = M_RUN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_RUN;
			valid_s1     <= 1'b0;
			local_q      <= '0;
			out_q        <= '0;
			retired_q    <= 1'b0;
			ptr_q        <= '0;
			wv_q         <= 1'b0;
			pend_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
			here_q       <= '0;
			root_q       <= '0;
			parent_q     <= '0;
		end else begin
			mode_q       <= mode_d;
			valid_s1     <= valid_s1_d;
			local_q      <= local_d;
			out_q        <= out_d;
			retired_q    <= retired_d;
			ptr_q        <= ptr_d;
			wv_q         <= wv_d;
			pend_valid_q <= pend_valid_d;
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_HERE:   here_q   <= cfg_data;
					REG_ROOT:   root_q   <= cfg_data;
					REG_PARENT: parent_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= in_action;
			cnt_s1 <= in_count;
			idx_s1 <= (in_action == ACT_LOCAL_SPAWN) ? place_idx(in_place) : par_idx;
		end
		walk_idx_s1  <= walk_idx_d;
		pend_place_q <= pend_place_d;
		pend_count_q <= pend_count_d;
		if (push) begin
			m_ackv_q  <= p_ackv;
			m_place_q <= p_place;
			m_count_q <= p_count;
			m_term_q  <= p_term;
			m_ret_q   <= p_ret;
			m_err_q   <= p_err;
			m_last_q  <= p_last;
		end
	end

	assign s_axis_tready = in_ready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_ackv_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {m_err_q, m_ret_q, m_term_q, m_count_q, m_place_q};

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!m_valid_q || m_axis_tready))
		else $error("result pushed into a full output register");

	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> (mode_q == M_RUN))
		else $error("input transfer taken during a walk");

	a_retired_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		retired_q |=> retired_q)
		else $error("retired flag cleared");

	a_pack_parent: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_PACK) |-> need_par)
		else $error("parent ack without idle non-root state");

endmodule
